@@ hw/rtl/linear_resample_downmix_pwm_assert.svh @@
// assertion macros shared by the resampler modules
`ifndef LINEAR_RESAMPLE_DOWNMIX_PWM_ASSERT_SVH
`define LINEAR_RESAMPLE_DOWNMIX_PWM_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LRD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define LRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/lrdp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrdp_pkg
// shared types and constants of the resampler
// ---------------------------------------------------------------------------
package lrdp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DUTY_W     = 14;
    localparam int STEP_W     = 37;
    localparam int GAIN_W     = 16;
    localparam int CHAN_W     = 4;
    localparam int SKIP_W     = 5;
    localparam int FRAC_W     = 32;
    localparam int SKIP_MAX   = 31;

    // register indexes
    localparam logic [1:0] REG_CHANNELS   = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [1:0] REG_GAIN       = 2'd2;

    // back end sequencer
    typedef enum logic [2:0] {
        BE_IDLE,
        BE_ACC,
        BE_ROUND,
        BE_MUL,
        BE_DIV,
        BE_OUT
    } be_state_t;

    // one completed frame job handed from front to back
    typedef struct packed {
        logic [FRAC_W-1:0] phase;
    } job_t;

endpackage

@@ hw/rtl/lrdp_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrdp_front
// gathers interleaved samples into frames and queues emission jobs
// ---------------------------------------------------------------------------
module lrdp_front #(
    parameter int MAX_CHANNELS = 8,
    parameter int CP_W         = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lrdp_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_restart,
    input  logic [lrdp_pkg::CHAN_W-1:0]         eff_ch,
    input  logic                                job_busy,
    output logic                                job_valid,
    input  logic                                job_done,
    input  logic [lrdp_pkg::SKIP_W-1:0]         skip_new,
    input  logic [lrdp_pkg::FRAC_W-1:0]         frac_new,
    output logic [lrdp_pkg::FRAC_W-1:0]         job_phase,
    output logic signed [lrdp_pkg::SAMPLE_W-1:0] prev_frame [MAX_CHANNELS],
    output logic signed [lrdp_pkg::SAMPLE_W-1:0] cur_frame  [MAX_CHANNELS]
);

    logic signed [lrdp_pkg::SAMPLE_W-1:0] prev_reg [MAX_CHANNELS];
    logic signed [lrdp_pkg::SAMPLE_W-1:0] cur_reg  [MAX_CHANNELS];
    logic [CP_W-1:0]               pos_reg;
    logic [lrdp_pkg::FRAC_W-1:0]   frac_reg;
    logic [lrdp_pkg::SKIP_W-1:0]   skip_reg;
    logic                          job_reg;
    logic [CP_W:0]                 pos_eff;
    logic [CP_W-1:0]               pos_w;
    logic                          frame_done;
    logic [lrdp_pkg::SKIP_W-1:0]   skip_base;
    logic [lrdp_pkg::SKIP_W-1:0]   skip_dec;
    logic                          accept;

    // the frame store is shared with the back end, so one job at a time
    assign s_ready   = !job_reg && !job_busy;
    assign accept    = s_valid && s_ready;
    assign job_valid = job_reg;
    assign job_phase = frac_reg;

    always_comb begin
        pos_eff = s_restart ? '0 : {1'b0, pos_reg};
        if (pos_eff >= (CP_W+1)'(eff_ch)) begin
            pos_eff = (CP_W+1)'(eff_ch) - 1'b1;
        end
        pos_w      = pos_eff[CP_W-1:0];
        frame_done = (pos_eff + 1'b1) >= (CP_W+1)'(eff_ch);
        skip_base  = s_restart ? lrdp_pkg::SKIP_W'(2) : skip_reg;
        skip_dec   = (skip_base != '0) ? skip_base - 1'b1 : skip_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            frac_reg <= '0;
            skip_reg <= lrdp_pkg::SKIP_W'(2);
            job_reg  <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
        end else begin
            if (job_done) begin
                job_reg  <= 1'b0;
                skip_reg <= skip_new;
                frac_reg <= frac_new;
            end
            if (accept) begin
                // a restart always lands on position zero
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    if (pos_w == '0) begin
                        prev_reg[i] <= s_restart ? '0 : cur_reg[i];
                    end
                    if (CP_W'(i) == pos_w) begin
                        cur_reg[i] <= s_sample;
                    end else if (s_restart) begin
                        cur_reg[i] <= '0;
                    end
                end
                if (s_restart) begin
                    frac_reg <= '0;
                end
                if (frame_done) begin
                    pos_reg  <= '0;
                    skip_reg <= skip_dec;
                    job_reg  <= (skip_dec == '0);
                end else begin
                    pos_reg  <= pos_w + 1'b1;
                    skip_reg <= skip_base;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            prev_frame[i] = prev_reg[i];
            cur_frame[i]  = cur_reg[i];
        end
    end

    `include "linear_resample_downmix_pwm_assert.svh"
    `LRD_ASSERT_IMP(a_job_stalls_input, aclk, aresetn, job_reg, !s_ready)
    `LRD_ASSERT_IMP(a_pos_in_range, aclk, aresetn, 1'b1, pos_reg <= CP_W'(MAX_CHANNELS - 1))
    `LRD_ASSERT_NEXT(a_done_clears, aclk, aresetn, job_done, !job_reg)

endmodule

@@ hw/rtl/lrdp_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrdp_back
// per output: channel sum, rounding, gain, divide by channels, pwm duty
// ---------------------------------------------------------------------------
module lrdp_back #(
    parameter int MAX_CHANNELS = 8,
    parameter int PWM_PERIOD   = 16000,
    parameter int MAX_BURST    = 16,
    parameter int CP_W         = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 job_valid,
    input  logic [lrdp_pkg::FRAC_W-1:0]          job_phase,
    output logic                                 job_busy,
    output logic                                 job_done,
    output logic [lrdp_pkg::SKIP_W-1:0]          skip_new,
    output logic [lrdp_pkg::FRAC_W-1:0]          frac_new,
    input  logic signed [lrdp_pkg::SAMPLE_W-1:0] prev_frame [MAX_CHANNELS],
    input  logic signed [lrdp_pkg::SAMPLE_W-1:0] cur_frame  [MAX_CHANNELS],
    input  logic [lrdp_pkg::CHAN_W-1:0]          eff_ch,
    input  logic [lrdp_pkg::STEP_W-1:0]          phase_step,
    input  logic [lrdp_pkg::GAIN_W-1:0]          gain,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lrdp_pkg::SAMPLE_W-1:0] m_mono_sample,
    output logic [lrdp_pkg::DUTY_W-1:0]          m_pwm_duty,
    output logic                                 m_last
);

    localparam int BC_W  = $clog2(MAX_BURST + 1);
    localparam int SUM_W = 54;        // 16 channels * 2^47
    localparam int M_W   = 40;
    localparam int P_W   = 57;
    localparam int DEN_W = 36;
    localparam int Q_W   = 22;
    localparam int HALF  = PWM_PERIOD / 2;

    lrdp_pkg::be_state_t state_reg, state_next;

    logic [lrdp_pkg::STEP_W:0]    p_reg;
    logic [BC_W-1:0]              n_reg;
    logic [CP_W:0]                c_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [M_W-1:0]        m_reg;
    logic                         neg_reg;
    logic [P_W-1:0]               rem_reg;
    logic [Q_W-1:0]               q_reg;
    logic [5:0]                   dcnt_reg;
    logic signed [lrdp_pkg::SAMPLE_W-1:0] y_out_reg;
    logic [lrdp_pkg::DUTY_W-1:0]  duty_out_reg;
    logic                         last_out_reg;
    logic                         ovalid_reg;

    logic signed [lrdp_pkg::SAMPLE_W:0] diff;
    logic signed [SUM_W-1:0]      term;
    logic [SUM_W-1:0]             sum_mag;
    logic [SUM_W-1:0]             m_mag;
    logic [P_W-1:0]               prod_mag;
    logic [DEN_W-1:0]             den;
    logic [P_W:0]                 trial;
    logic signed [Q_W:0]          y_s;
    logic signed [lrdp_pkg::SAMPLE_W-1:0] y_sat;
    logic [31:0]                  duty_w;
    logic                         more;
    logic [lrdp_pkg::STEP_W:0]    p_adv;
    logic [lrdp_pkg::STEP_W:0]    p_fin;
    logic [lrdp_pkg::STEP_W-lrdp_pkg::FRAC_W:0] whole;
    logic [CP_W-1:0]              c_idx;
    logic                         out_load;

    assign c_idx    = c_reg[CP_W-1:0];
    assign den      = DEN_W'({eff_ch, 31'd0});
    assign job_busy = (state_reg != lrdp_pkg::BE_IDLE);
    assign p_adv    = p_reg + (lrdp_pkg::STEP_W+1)'(phase_step);
    assign more     = (p_adv[lrdp_pkg::STEP_W:lrdp_pkg::FRAC_W] == '0)
                      && (n_reg + 1'b1 < BC_W'(MAX_BURST));
    assign p_fin    = p_adv;
    assign out_load = (state_reg == lrdp_pkg::BE_OUT) && (!ovalid_reg || m_ready);

    always_comb begin
        diff    = (lrdp_pkg::SAMPLE_W+1)'(cur_frame[c_idx])
                  - (lrdp_pkg::SAMPLE_W+1)'(prev_frame[c_idx]);
        term    = (SUM_W'(prev_frame[c_idx]) <<< 32)
                  + SUM_W'(diff) * $signed({1'b0, p_reg[lrdp_pkg::FRAC_W-1:0]});
        sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        m_mag   = (sum_mag + SUM_W'(32768)) >> 16;
        prod_mag = P_W'(m_reg[M_W-1] ? -m_reg : m_reg) * P_W'(gain);
        trial   = {1'b0, rem_reg} - ((P_W+1)'(den) << dcnt_reg);
        y_s     = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        if (y_s > (Q_W+1)'(32767)) begin
            y_sat = 16'sh7fff;
        end else if (y_s < -(Q_W+1)'(32768)) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_s[lrdp_pkg::SAMPLE_W-1:0];
        end
        duty_w = ((32'(y_sat) + 32'd32768) * 32'(HALF)) >> 15;
        if (duty_w > 32'(PWM_PERIOD)) begin
            duty_w = 32'(PWM_PERIOD);
        end
        whole = p_fin[lrdp_pkg::STEP_W:lrdp_pkg::FRAC_W];
        if (whole == '0) whole = 6'(1);
        if (whole > 6'(lrdp_pkg::SKIP_MAX)) whole = 6'(lrdp_pkg::SKIP_MAX);
        skip_new = lrdp_pkg::SKIP_W'(whole);
        frac_new = p_fin[lrdp_pkg::FRAC_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lrdp_pkg::BE_IDLE:  if (job_valid) state_next = lrdp_pkg::BE_ACC;
            lrdp_pkg::BE_ACC:   if (c_reg + 1'b1 >= (CP_W+1)'(eff_ch)) state_next = lrdp_pkg::BE_ROUND;
            lrdp_pkg::BE_ROUND: state_next = lrdp_pkg::BE_MUL;
            lrdp_pkg::BE_MUL:   state_next = lrdp_pkg::BE_DIV;
            lrdp_pkg::BE_DIV:   if (dcnt_reg == '0) state_next = lrdp_pkg::BE_OUT;
            lrdp_pkg::BE_OUT: begin
                if (!ovalid_reg || m_ready) begin
                    state_next = more ? lrdp_pkg::BE_ACC : lrdp_pkg::BE_IDLE;
                end
            end
            default: state_next = lrdp_pkg::BE_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        job_done = out_load && !more;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lrdp_pkg::BE_IDLE;
            ovalid_reg <= 1'b0;
            n_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_ready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                lrdp_pkg::BE_IDLE: begin
                    p_reg   <= (lrdp_pkg::STEP_W+1)'(job_phase);
                    n_reg   <= '0;
                    c_reg   <= '0;
                    sum_reg <= '0;
                end
                lrdp_pkg::BE_ACC: begin
                    sum_reg <= sum_reg + term;
                    c_reg   <= c_reg + 1'b1;
                end
                lrdp_pkg::BE_ROUND: begin
                    m_reg <= sum_reg[SUM_W-1] ? -M_W'(m_mag) : M_W'(m_mag);
                end
                lrdp_pkg::BE_MUL: begin
                    neg_reg  <= m_reg[M_W-1];
                    rem_reg  <= prod_mag + P_W'(den >> 1);
                    q_reg    <= '0;
                    dcnt_reg <= 6'(Q_W - 1);
                end
                lrdp_pkg::BE_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (!trial[P_W]) begin
                        rem_reg <= trial[P_W-1:0];
                        q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                    end
                    if (dcnt_reg != '0) dcnt_reg <= dcnt_reg - 1'b1;
                end
                lrdp_pkg::BE_OUT: begin
                    if (out_load) begin
                        y_out_reg    <= y_sat;
                        duty_out_reg <= duty_w[lrdp_pkg::DUTY_W-1:0];
                        last_out_reg <= !more;
                        p_reg        <= p_adv;
                        n_reg        <= n_reg + 1'b1;
                        c_reg        <= '0;
                        sum_reg      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = ovalid_reg;
    assign m_mono_sample = y_out_reg;
    assign m_pwm_duty    = duty_out_reg;
    assign m_last        = last_out_reg;

    `include "linear_resample_downmix_pwm_assert.svh"
    `LRD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_mono_sample))
    `LRD_ASSERT_IMP(a_done_in_out, aclk, aresetn, job_done, state_reg == lrdp_pkg::BE_OUT)
    `LRD_ASSERT_IMP(a_burst_bound, aclk, aresetn, 1'b1, n_reg <= BC_W'(MAX_BURST))

endmodule

@@ hw/rtl/linear_resample_downmix_pwm.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_resample_downmix_pwm
// linear interpolation resampler with channel downmix, gain and pwm duty
// ---------------------------------------------------------------------------
// channel   | direction | fields
// s_        | in        | sample, restart
// m_        | out       | mono_sample, pwm_duty, last
// apb       | in/out    | channels, phase_step, gain
//
// a sample that completes no emitting frame leaves the input ready for the next sample
// each result passes through channel accumulate, round, multiply
// and a restoring divide by channels * 2^31
// input stalls while a frame's burst of results is being produced
// synchronous active-low reset restores registers and clears history
module linear_resample_downmix_pwm #(
    parameter int MAX_CHANNELS = 8,
    parameter int PWM_PERIOD   = 16000,
    parameter int MAX_BURST    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_sample,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_mono_sample,
    output logic [13:0] m_pwm_duty,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CP_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [lrdp_pkg::CHAN_W-1:0] channels_reg;
    logic [lrdp_pkg::STEP_W-1:0] step_reg;
    logic [lrdp_pkg::GAIN_W-1:0] gain_reg;
    logic [lrdp_pkg::CHAN_W-1:0] eff_ch;
    logic [1:0]                  reg_idx;
    logic                        job_valid, job_busy, job_done;
    logic [lrdp_pkg::SKIP_W-1:0] skip_new;
    logic [lrdp_pkg::FRAC_W-1:0] frac_new, job_phase;
    logic signed [15:0] prev_frame [MAX_CHANNELS];
    logic signed [15:0] cur_frame  [MAX_CHANNELS];

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg <= 4'd2;
            step_reg     <= 37'h1_0000_0000;
            gain_reg     <= 16'd32768;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (reg_idx)
                lrdp_pkg::REG_CHANNELS:   channels_reg <= pwdata[3:0];
                lrdp_pkg::REG_PHASE_STEP: step_reg     <= pwdata[36:0];
                lrdp_pkg::REG_GAIN:       gain_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lrdp_pkg::REG_CHANNELS:   prdata = 64'(channels_reg);
            lrdp_pkg::REG_PHASE_STEP: prdata = 64'(step_reg);
            lrdp_pkg::REG_GAIN:       prdata = 64'(gain_reg);
            default:                  prdata = '0;
        endcase
        if (channels_reg == '0) begin
            eff_ch = 4'd1;
        end else if (32'(channels_reg) > MAX_CHANNELS) begin
            eff_ch = lrdp_pkg::CHAN_W'(MAX_CHANNELS);
        end else begin
            eff_ch = channels_reg;
        end
    end

    lrdp_front #(.MAX_CHANNELS(MAX_CHANNELS), .CP_W(CP_W)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_sample, .s_restart,
        .eff_ch, .job_busy, .job_valid, .job_done, .skip_new, .frac_new,
        .job_phase, .prev_frame, .cur_frame
    );

    lrdp_back #(.MAX_CHANNELS(MAX_CHANNELS), .PWM_PERIOD(PWM_PERIOD),
                .MAX_BURST(MAX_BURST), .CP_W(CP_W)) u_back (
        .aclk, .aresetn, .job_valid, .job_phase, .job_busy, .job_done,
        .skip_new, .frac_new, .prev_frame, .cur_frame, .eff_ch,
        .phase_step(step_reg), .gain(gain_reg), .m_valid, .m_ready,
        .m_mono_sample, .m_pwm_duty, .m_last
    );

endmodule
